// ===== sv/tdmh_pkg.sv =====
// Package with shared types and constants for the timer deadline min-heap.
package tdmh_pkg;

   localparam int HEAP_DEPTH   = 1024;
   localparam int HANDLE_COUNT = 1024;
   localparam int TIME_WIDTH   = 48;
   localparam int SLOT_W       = $clog2(HEAP_DEPTH);
   localparam int HANDLE_W     = 10;
   localparam int HIDX_W       = $clog2(HANDLE_COUNT);
   localparam int COUNT_W      = 11;
   localparam int DL_W         = 48;
   localparam int POS_W        = SLOT_W + 1;
   localparam int SLOT_DATA_W  = TIME_WIDTH + HIDX_W;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_UPDATE = 3'd2,
      CMD_POP    = 3'd3,
      CMD_PEEK   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_PRESENT = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

endpackage

// ===== sv/tdmh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tdmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/timer_deadline_min_heap_core.sv =====
// Top level of the timer deadline min-heap with handle position map.
//
//   Channel | Direction | Ports
//   req     | in        | req_tvalid, req_tready, req_tdata
//   rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata
//
// Peek, refused commands and commands on an empty heap pass from the map read
// through the decision and the root read to the output register. A sift climbs
// one level per parent read and compare, and descends one level per left-child
// read, right-child read and compare, since the slot RAM gives one read per cycle.
// After reset a clearing pass marks every handle absent before the first item is
// taken. The result waits in an output register, and the next item is taken in
// the cycle after the result has been handed over.
module timer_deadline_min_heap_core
   import tdmh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // command[2:0], event_handle[12:3], deadline[60:13]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata   // status[2:0], front_handle[12:3], front_deadline[60:13],
                                    // front_valid[61], became_front[62], entry_count[73:63]
);

   typedef enum logic [13:0] {
      S_CLEAR   = 14'h0001,
      S_IDLE    = 14'h0002,
      S_MAPRD   = 14'h0004,
      S_DECIDE  = 14'h0008,
      S_LASTRD  = 14'h0010,
      S_LASTGET = 14'h0020,
      S_UPRD    = 14'h0040,
      S_UPCMP   = 14'h0080,
      S_DNRDL   = 14'h0100,
      S_DNRDR   = 14'h0200,
      S_DNCMP   = 14'h0400,
      S_PLACE   = 14'h0800,
      S_ROOTRD  = 14'h1000,
      S_OUT     = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   logic [HIDX_W-1:0]     clr_ff, clr_in;
   cmd_type               cmd_ff, cmd_in;
   logic [HANDLE_W-1:0]   hdl_ff, hdl_in;
   logic [TIME_WIDTH-1:0] dl_ff, dl_in;
   logic [COUNT_W-1:0]    fill_ff, fill_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [HIDX_W-1:0]     mh_ff, mh_in;
   logic [TIME_WIDTH-1:0] md_ff, md_in;
   logic [HIDX_W-1:0]     lh_ff, lh_in;
   logic [TIME_WIDTH-1:0] ld_ff, ld_in;
   logic                  moved_ff, moved_in;
   logic                  popped_ff, popped_in;
   status_type            st_ff, st_in;
   logic                  became_ff, became_in;
   logic [HIDX_W-1:0]     ph_ff, ph_in;
   logic [TIME_WIDTH-1:0] pd_ff, pd_in;
   logic                  rv_ff, rv_in;
   logic [79:0]           rd_ff, rd_in;

   logic                   s_we;
   logic [SLOT_W-1:0]      s_wa, s_ra;
   logic [SLOT_DATA_W-1:0] s_wd, s_rd;
   logic                   m_we;
   logic [HIDX_W-1:0]      m_wa, m_ra;
   logic [POS_W:0]         m_wd, m_rd;

   logic [TIME_WIDTH-1:0] rdl;
   logic [HIDX_W-1:0]     rhd;
   logic [POS_W-1:0]      parent;
   logic [POS_W:0]        lchild;
   logic [POS_W:0]        rchild;
   logic [POS_W:0]        fill_x;
   logic                  h_ok;

   assign rdl = s_rd[TIME_WIDTH-1:0];
   assign rhd = s_rd[SLOT_DATA_W-1:TIME_WIDTH];
   assign parent = (pos_ff - 1'b1) >> 1;
   assign lchild = {pos_ff, 1'b1};
   assign rchild = lchild + 1'b1;
   assign fill_x = {1'b0, fill_ff};
   assign h_ok = ({{(32-HANDLE_W){1'b0}}, hdl_ff} < HANDLE_COUNT);

   tdmh_ram #(.WIDTH(SLOT_DATA_W), .DEPTH(HEAP_DEPTH)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd)
   );

   // Map entry: present bit on top, slot position below.
   tdmh_ram #(.WIDTH(POS_W + 1), .DEPTH(HANDLE_COUNT)) u_map (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd)
   );

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; cmd_in = cmd_ff; hdl_in = hdl_ff;
      dl_in = dl_ff; fill_in = fill_ff; pos_in = pos_ff;
      mh_in = mh_ff; md_in = md_ff; lh_in = lh_ff; ld_in = ld_ff;
      moved_in = moved_ff; popped_in = popped_ff;
      st_in = st_ff; became_in = became_ff; ph_in = ph_ff; pd_in = pd_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
      m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_wa = clr_ff; m_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == HIDX_W'(HANDLE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_tdata[2:0])
                  CMD_INSERT, CMD_REMOVE, CMD_UPDATE, CMD_POP: begin
                     cmd_in = cmd_type'(req_tdata[2:0]);
                  end
                  default: cmd_in = CMD_PEEK;
               endcase
               hdl_in = req_tdata[12:3];
               dl_in = TIME_WIDTH'(req_tdata[60:13]);
               st_in = ST_OK; became_in = 1'b0; popped_in = 1'b0;
               moved_in = 1'b0;
               state_in = S_MAPRD;
            end
         end
         S_MAPRD: begin
            m_ra = HIDX_W'(hdl_ff);
            s_ra = '0;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // m_rd is the handle's map entry, s_rd the root slot.
            state_in = S_ROOTRD;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (!h_ok) st_in = ST_ABSENT;
                  else if (m_rd[POS_W]) st_in = ST_PRESENT;
                  else if (fill_ff >= COUNT_W'(HEAP_DEPTH)) st_in = ST_FULL;
                  else begin
                     mh_in = HIDX_W'(hdl_ff); md_in = dl_ff;
                     pos_in = POS_W'(fill_ff);
                     fill_in = fill_ff + 1'b1;
                     state_in = S_UPRD;
                  end
               end
               CMD_REMOVE, CMD_UPDATE: begin
                  if (!h_ok || !m_rd[POS_W]) st_in = ST_ABSENT;
                  else begin
                     pos_in = m_rd[POS_W-1:0];
                     if (cmd_ff == CMD_UPDATE) begin
                        mh_in = HIDX_W'(hdl_ff); md_in = dl_ff;
                        state_in = S_UPRD;
                     end else begin
                        m_we = 1'b1; m_wa = HIDX_W'(hdl_ff); m_wd = '0;
                        fill_in = fill_ff - 1'b1;
                        state_in = S_LASTRD;
                     end
                  end
               end
               CMD_POP: begin
                  if (fill_ff == '0) st_in = ST_EMPTY;
                  else begin
                     popped_in = 1'b1; ph_in = rhd; pd_in = rdl;
                     m_we = 1'b1; m_wa = rhd; m_wd = '0;
                     pos_in = '0;
                     fill_in = fill_ff - 1'b1;
                     state_in = S_LASTRD;
                  end
               end
               default: begin
                  if (fill_ff == '0) st_in = ST_EMPTY;
               end
            endcase
         end
         S_LASTRD: begin
            // fill_ff is the new count, so it indexes the last slot.
            if (pos_ff >= fill_ff) state_in = S_ROOTRD;
            else begin
               s_ra = SLOT_W'(fill_ff);
               state_in = S_LASTGET;
            end
         end
         S_LASTGET: begin
            mh_in = rhd; md_in = rdl;
            state_in = S_UPRD;
         end
         S_UPRD: begin
            if (pos_ff == '0) begin
               state_in = (moved_ff || cmd_ff == CMD_INSERT) ? S_PLACE : S_DNRDL;
            end else begin
               s_ra = SLOT_W'(parent);
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (md_ff < rdl) begin
               s_we = 1'b1; s_wa = SLOT_W'(pos_ff); s_wd = s_rd;
               m_we = 1'b1; m_wa = rhd; m_wd = {1'b1, pos_ff};
               pos_in = parent;
               moved_in = 1'b1;
               state_in = S_UPRD;
            end else begin
               state_in = (moved_ff || cmd_ff == CMD_INSERT) ? S_PLACE : S_DNRDL;
            end
         end
         S_DNRDL: begin
            if (lchild >= fill_x) begin
               state_in = S_PLACE;
            end else begin
               s_ra = SLOT_W'(lchild);
               state_in = S_DNRDR;
            end
         end
         S_DNRDR: begin
            lh_in = rhd; ld_in = rdl;
            s_ra = SLOT_W'(rchild);
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            // ld/lh: left child; s_rd: right child.
            if (rchild >= fill_x || ld_ff < rdl) begin
               if (ld_ff < md_ff) begin
                  s_we = 1'b1; s_wa = SLOT_W'(pos_ff); s_wd = {lh_ff, ld_ff};
                  m_we = 1'b1; m_wa = lh_ff; m_wd = {1'b1, pos_ff};
                  pos_in = POS_W'(lchild);
                  state_in = S_DNRDL;
               end else state_in = S_PLACE;
            end else begin
               if (rdl < md_ff) begin
                  s_we = 1'b1; s_wa = SLOT_W'(pos_ff); s_wd = s_rd;
                  m_we = 1'b1; m_wa = rhd; m_wd = {1'b1, pos_ff};
                  pos_in = POS_W'(rchild);
                  state_in = S_DNRDL;
               end else state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            s_we = 1'b1; s_wa = SLOT_W'(pos_ff); s_wd = {mh_ff, md_ff};
            m_we = 1'b1; m_wa = mh_ff; m_wd = {1'b1, pos_ff};
            if (cmd_ff == CMD_INSERT && pos_ff == '0) became_in = 1'b1;
            state_in = S_ROOTRD;
         end
         S_ROOTRD: begin
            s_ra = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1;
            rd_in = '0;
            rd_in[2:0] = st_ff;
            rd_in[73:63] = fill_ff;
            rd_in[62] = became_ff;
            if (popped_ff) begin
               rd_in[12:3] = HANDLE_W'(ph_ff);
               rd_in[60:13] = DL_W'(pd_ff);
               rd_in[61] = 1'b1;
            end else if (fill_ff != '0) begin
               rd_in[12:3] = HANDLE_W'(rhd);
               rd_in[60:13] = DL_W'(rdl);
               rd_in[61] = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         fill_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_ff <= fill_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; hdl_ff <= hdl_in; dl_ff <= dl_in; pos_ff <= pos_in;
      mh_ff <= mh_in; md_ff <= md_in; lh_ff <= lh_in;
      ld_ff <= ld_in; moved_ff <= moved_in;
      popped_ff <= popped_in; st_ff <= st_in; became_ff <= became_in;
      ph_ff <= ph_in; pd_ff <= pd_in; rd_ff <= rd_in;
   end

endmodule

// ===== sv/tdmh_checker.sv =====
// Port-level checker for the timer deadline min-heap, bound to the top level.
module tdmh_checker
   import tdmh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("item taken while result pending");

   a_no_result_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("result too early");

   a_empty_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == ST_EMPTY) |-> !rsp_tdata[61])
      else $error("empty with valid front");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[73:63] <= COUNT_W'(HEAP_DEPTH))
      else $error("count out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");

endmodule

bind timer_deadline_min_heap_core tdmh_checker u_tdmh_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
